FILE: rtl/ssh_pkg.sv
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared widths, payload types and helpers for the segment/sphere hit test.
// ----------------------------------------------------------------------------
package ssh_pkg;

  // coordinate width and the widths that follow from it
  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;      // difference of two coords
  localparam int SQ_W       = 2 * COORD_BITS;      // square of a difference
  localparam int PROD_W     = 2 * DIFF_W;          // signed product of differences
  localparam int HALF_W     = DIFF_W;              // split width for wide squares
  localparam int D2_W       = 2 * HALF_W;          // sum of three squares
  localparam int XS_W       = PROD_W + 1;          // cross product component
  localparam int DOT_W      = PROD_W + 2;          // dot product
  localparam int RDP_W      = SQ_W + HALF_W;       // partial of r^2 * |d|^2
  localparam int WIDE_W     = 4 * HALF_W;          // |d x a|^2 and r^2 * |d|^2

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] len_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;

  // products of the vector differences
  typedef struct packed {
    logic                   valid;
    logic [2:0][SQ_W-1:0]   dsq;
    logic [2:0][SQ_W-1:0]   asq;
    logic [2:0][SQ_W-1:0]   bsq;
    logic [2:0][PROD_W-1:0] cr_p;
    logic [2:0][PROD_W-1:0] cr_q;
    logic [2:0][PROD_W-1:0] adp;
    logic [2:0][PROD_W-1:0] bdp;
    logic [SQ_W-1:0]        r2;
  } prod_t;

  // wide terms and decision flags ready for the final compare
  typedef struct packed {
    logic                   valid;
    logic [2:0][WIDE_W-1:0] xsq;
    logic [WIDE_W-1:0]      rd;
    logic                   d_zero;
    logic                   a_in;
    logic                   b_in;
    logic                   straddle;
  } term_t;

  // sign extend a coordinate by one bit
  function automatic diff_t sext(input coord_t v);
    return {v[COORD_BITS-1], v};
  endfunction

  // signed product of two differences
  function automatic logic [PROD_W-1:0] smul(input diff_t x, input diff_t y);
    logic signed [PROD_W-1:0] p;
    p = x * y;
    return p;
  endfunction

endpackage

FILE: rtl/ssh_front.sv
// ----------------------------------------------------------------------------
// ssh_front
// Stage 1 forms the difference vectors, stage 2 forms all first products.
// ----------------------------------------------------------------------------
module ssh_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  ssh_pkg::coord_t seg_start_x,
  input  ssh_pkg::coord_t seg_start_y,
  input  ssh_pkg::coord_t seg_start_z,
  input  ssh_pkg::coord_t seg_end_x,
  input  ssh_pkg::coord_t seg_end_y,
  input  ssh_pkg::coord_t seg_end_z,
  input  ssh_pkg::coord_t center_x,
  input  ssh_pkg::coord_t center_y,
  input  ssh_pkg::coord_t center_z,
  input  ssh_pkg::len_t   radius,
  output ssh_pkg::prod_t  prod
);
  import ssh_pkg::*;

  coord_t s_c [3];
  coord_t e_c [3];
  coord_t c_c [3];

  logic  v1;
  diff_t d [3];
  diff_t a [3];
  diff_t b [3];
  len_t  r;

  prod_t prod_next;

  assign s_c[0] = seg_start_x;
  assign s_c[1] = seg_start_y;
  assign s_c[2] = seg_start_z;
  assign e_c[0] = seg_end_x;
  assign e_c[1] = seg_end_y;
  assign e_c[2] = seg_end_z;
  assign c_c[0] = center_x;
  assign c_c[1] = center_y;
  assign c_c[2] = center_z;

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  // stage 1: d = E - S, a = C - S, b = C - E
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d[i] <= sext(e_c[i]) - sext(s_c[i]);
      a[i] <= sext(c_c[i]) - sext(s_c[i]);
      b[i] <= sext(c_c[i]) - sext(e_c[i]);
    end
    r <= radius;
  end

  // stage 2 products
  always_comb begin
    logic [PROD_W-1:0] pd;
    logic [PROD_W-1:0] pa;
    logic [PROD_W-1:0] pb;
    prod_next.valid = v1;
    for (int i = 0; i < 3; i++) begin
      pd = smul(d[i], d[i]);
      pa = smul(a[i], a[i]);
      pb = smul(b[i], b[i]);
      prod_next.dsq[i] = pd[SQ_W-1:0];
      prod_next.asq[i] = pa[SQ_W-1:0];
      prod_next.bsq[i] = pb[SQ_W-1:0];
      prod_next.adp[i] = smul(a[i], d[i]);
      prod_next.bdp[i] = smul(b[i], d[i]);
    end
    // cross product d x a, as pairs to subtract
    prod_next.cr_p[0] = smul(d[1], a[2]);
    prod_next.cr_q[0] = smul(d[2], a[1]);
    prod_next.cr_p[1] = smul(d[2], a[0]);
    prod_next.cr_q[1] = smul(d[0], a[2]);
    prod_next.cr_p[2] = smul(d[0], a[1]);
    prod_next.cr_q[2] = smul(d[1], a[0]);
    prod_next.r2 = r * r;
  end

  // stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else begin
      prod.valid <= prod_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod.dsq  <= prod_next.dsq;
    prod.asq  <= prod_next.asq;
    prod.bsq  <= prod_next.bsq;
    prod.cr_p <= prod_next.cr_p;
    prod.cr_q <= prod_next.cr_q;
    prod.adp  <= prod_next.adp;
    prod.bdp  <= prod_next.bdp;
    prod.r2   <= prod_next.r2;
  end

endmodule

FILE: rtl/ssh_cross.sv
// ----------------------------------------------------------------------------
// ssh_cross
// Stages 3 to 5: sums of squares, cross product magnitudes, split squaring
// of the cross components and of r^2 * |d|^2, and the decision flags.
// ----------------------------------------------------------------------------
module ssh_cross (
  input  logic           clk,
  input  logic           rst,
  input  ssh_pkg::prod_t prod,
  output ssh_pkg::term_t term
);
  import ssh_pkg::*;

  // stage 3 registers
  logic              v3;
  logic [D2_W-1:0]   d2;
  logic [D2_W-1:0]   a2;
  logic [D2_W-1:0]   b2;
  logic [SQ_W-1:0]   r2;
  logic [PROD_W-1:0] xmag [3];
  logic              ad_neg;
  logic              ad_zero;
  logic              bd_neg;
  logic              bd_zero;

  // stage 4 registers
  logic                v4;
  logic [2*HALF_W-1:0] hh [3];
  logic [2*HALF_W-1:0] hl [3];
  logic [2*HALF_W-1:0] ll [3];
  logic [RDP_W-1:0]    rd_lo;
  logic [RDP_W-1:0]    rd_hi;
  logic                d_zero;
  logic                a_in;
  logic                b_in;
  logic                straddle;

  logic [PROD_W-1:0]       xmag_next [3];
  logic signed [DOT_W-1:0] ad_next;
  logic signed [DOT_W-1:0] bd_next;

  // stage 3: magnitudes of cross components and the two dot products
  always_comb begin
    logic signed [XS_W-1:0] xs;
    logic        [XS_W-1:0] xa;
    for (int i = 0; i < 3; i++) begin
      xs = $signed({prod.cr_p[i][PROD_W-1], prod.cr_p[i]})
         - $signed({prod.cr_q[i][PROD_W-1], prod.cr_q[i]});
      xa = xs[XS_W-1] ? -xs : xs;
      xmag_next[i] = xa[PROD_W-1:0];
    end
    ad_next = $signed({{2{prod.adp[0][PROD_W-1]}}, prod.adp[0]})
            + $signed({{2{prod.adp[1][PROD_W-1]}}, prod.adp[1]})
            + $signed({{2{prod.adp[2][PROD_W-1]}}, prod.adp[2]});
    bd_next = $signed({{2{prod.bdp[0][PROD_W-1]}}, prod.bdp[0]})
            + $signed({{2{prod.bdp[1][PROD_W-1]}}, prod.bdp[1]})
            + $signed({{2{prod.bdp[2][PROD_W-1]}}, prod.bdp[2]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= prod.valid;
    end
  end

  always_ff @(posedge clk) begin
    d2 <= {2'b00, prod.dsq[0]} + {2'b00, prod.dsq[1]} + {2'b00, prod.dsq[2]};
    a2 <= {2'b00, prod.asq[0]} + {2'b00, prod.asq[1]} + {2'b00, prod.asq[2]};
    b2 <= {2'b00, prod.bsq[0]} + {2'b00, prod.bsq[1]} + {2'b00, prod.bsq[2]};
    r2 <= prod.r2;
    for (int i = 0; i < 3; i++) begin
      xmag[i] <= xmag_next[i];
    end
    ad_neg  <= ad_next[DOT_W-1];
    ad_zero <= (ad_next == '0);
    bd_neg  <= bd_next[DOT_W-1];
    bd_zero <= (bd_next == '0);
  end

  // stage 4: half-width partial products and the decision flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      hh[i] <= xmag[i][PROD_W-1:HALF_W] * xmag[i][PROD_W-1:HALF_W];
      hl[i] <= xmag[i][PROD_W-1:HALF_W] * xmag[i][HALF_W-1:0];
      ll[i] <= xmag[i][HALF_W-1:0] * xmag[i][HALF_W-1:0];
    end
    rd_lo    <= r2 * d2[HALF_W-1:0];
    rd_hi    <= r2 * d2[D2_W-1:HALF_W];
    d_zero   <= (d2 == '0);
    a_in     <= (a2 < {2'b00, r2});
    b_in     <= (b2 < {2'b00, r2});
    // center projects onto the closed segment
    straddle <= ad_zero | bd_zero | (ad_neg != bd_neg);
  end

  // stage 5: assemble the wide squares
  always_ff @(posedge clk) begin
    if (rst) begin
      term.valid <= 1'b0;
    end else begin
      term.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      term.xsq[i] <= {hh[i], ll[i]} + (WIDE_W'(hl[i]) << (HALF_W + 1));
    end
    term.rd       <= WIDE_W'(rd_lo) + (WIDE_W'(rd_hi) << HALF_W);
    term.d_zero   <= d_zero;
    term.a_in     <= a_in;
    term.b_in     <= b_in;
    term.straddle <= straddle;
  end

endmodule

FILE: rtl/ssh_decide.sv
// ----------------------------------------------------------------------------
// ssh_decide
// Stage 6 sums |d x a|^2, stage 7 compares it with r^2 * |d|^2 and
// registers the hit flag with its strobe.
// ----------------------------------------------------------------------------
module ssh_decide (
  input  logic           clk,
  input  logic           rst,
  input  ssh_pkg::term_t term,
  output logic           done,
  output logic           hit
);
  import ssh_pkg::*;

  logic              v6;
  logic [WIDE_W-1:0] x2;
  logic [WIDE_W-1:0] rd;
  logic              d_zero;
  logic              a_in;
  logic              b_in;
  logic              straddle;
  logic              hit_next;

  // stage 6: squared line distance times |d|^2
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= term.valid;
    end
  end

  always_ff @(posedge clk) begin
    x2       <= term.xsq[0] + term.xsq[1] + term.xsq[2];
    rd       <= term.rd;
    d_zero   <= term.d_zero;
    a_in     <= term.a_in;
    b_in     <= term.b_in;
    straddle <= term.straddle;
  end

  // point segment, line miss, projection inside, then endpoint inside
  always_comb begin
    if (d_zero) begin
      hit_next = a_in;
    end else if (x2 >= rd) begin
      hit_next = 1'b0;
    end else if (straddle) begin
      hit_next = 1'b1;
    end else begin
      hit_next = a_in | b_in;
    end
  end

  // stage 7: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
  end

  always_ff @(posedge clk) begin
    hit <= hit_next;
  end

endmodule

FILE: rtl/segment_sphere_hit_test.sv
// the hit flag is strobed by done when a taken start has come through the whole pipeline
// throughput: one item per cycle while busy is low, set by the seven-stage multiply pipeline
// busy is rst registered, so it rises and falls in the cycle after rst does; else items are taken every cycle
// reset clears every stage valid bit; items in flight are dropped
// the receiver cannot stall, so results leave on a fixed schedule
// ----------------------------------------------------------------------------
// segment_sphere_hit_test
// Segment against sphere hit test on exact squared integer quantities.
// ----------------------------------------------------------------------------
module segment_sphere_hit_test (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ssh_pkg::coord_t seg_start_x,
  input  ssh_pkg::coord_t seg_start_y,
  input  ssh_pkg::coord_t seg_start_z,
  input  ssh_pkg::coord_t seg_end_x,
  input  ssh_pkg::coord_t seg_end_y,
  input  ssh_pkg::coord_t seg_end_z,
  input  ssh_pkg::coord_t center_x,
  input  ssh_pkg::coord_t center_y,
  input  ssh_pkg::coord_t center_z,
  input  ssh_pkg::len_t   radius,
  output logic            done,
  output logic            hit
);
  import ssh_pkg::*;

  prod_t prod;
  term_t term;
  logic  accept;

  // hold off items after reset: busy is a registered copy of rst
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start & ~busy;

  ssh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .seg_start_x (seg_start_x),
    .seg_start_y (seg_start_y),
    .seg_start_z (seg_start_z),
    .seg_end_x   (seg_end_x),
    .seg_end_y   (seg_end_y),
    .seg_end_z   (seg_end_z),
    .center_x    (center_x),
    .center_y    (center_y),
    .center_z    (center_z),
    .radius      (radius),
    .prod        (prod)
  );

  ssh_cross u_cross (
    .clk  (clk),
    .rst  (rst),
    .prod (prod),
    .term (term)
  );

  ssh_decide u_decide (
    .clk  (clk),
    .rst  (rst),
    .term (term),
    .done (done),
    .hit  (hit)
  );

  // reset empties the pipe and holds off the next item
  a_reset_clears: assert property (@(posedge clk) rst |=> (!done && busy))
    else $error("pipeline not cleared by reset");

  // every taken item comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##7 done)
    else $error("item lost in pipeline");

  // no result can leave while the block is still coming out of reset
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result during reset hold-off");

endmodule
